// File: rtl/core/mrrc_pkg.sv
`default_nettype none

package mrrc_pkg;

    localparam int MAX_FRAME_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_CAP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_EXTRA  = 2'd3;

    localparam logic [6:0]  RETRY_LIMIT_RST = 7'd3;
    localparam logic [9:0]  BASE_DELAY_RST  = 10'd100;
    localparam logic [15:0] DELAY_CAP_RST   = 16'd1000;
    localparam logic [7:0]  BUSY_EXTRA_RST  = 8'h20;

    localparam logic [1:0] FN_START   = 2'd0;
    localparam logic [1:0] FN_BYTE    = 2'd1;
    localparam logic [1:0] FN_TIMEOUT = 2'd2;
    localparam logic [1:0] FN_LINK    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_CRC       = 3'd4;
    localparam logic [2:0] ST_EXCEPTION = 3'd5;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  EXC_BUSY   = 8'h06;
    localparam logic [7:0]  EXC_ACK    = 8'h05;
    localparam logic [8:0]  MIN_FRAME  = 9'd4;
    localparam logic [8:0]  COUNT_SAT  = 9'd256;
    localparam logic [6:0]  ATTEMPT_SAT = 7'd127;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic        retry;
        logic [15:0] backoff_ms;
        logic [6:0]  attempt;
        logic [8:0]  frame_length;
    } t_result;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/modbus_rtu_response_checker.sv
// Modbus RTU response checker for the master side of a link.
// Input channel (i_valid, o_stall, i_item): one item per accepted cycle, either
// a transaction start, a received byte with its end-of-frame mark, a response
// timeout or a link failure. A start item clears the attempt count.
// Output channel (o_valid, i_stall, o_result): one result at the end of each
// attempt with status, exception code, retry decision, backoff delay, attempt
// number and frame length. Items that do not end an attempt give no result.
// A result is registered into the result queue when its item is accepted.
// Throughput is one item per cycle while o_stall is low; the CRC step for one byte and
// the backoff compare fit between the frame state and the result queue.
// A two-entry result queue lets the block keep accepting items while a result
// waits; o_stall rises only when both entries are held by a stalled receiver.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once
// and are meant for times when the block is idle.
// Synchronous active-low reset restores the register defaults (retry limit 3,
// base delay 100, cap 1000, vendor busy code 0x20), empties the result queue
// and clears the frame state and attempt count.
`default_nettype none

module modbus_rtu_response_checker
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_item                 i_item,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_result                    o_result
);

    localparam logic [8:0] FRAME_LIMIT = 9'(MAX_FRAME);

    logic [6:0]  r_retry_limit;
    logic [9:0]  r_base_delay;
    logic [15:0] r_delay_cap;
    logic [7:0]  r_busy_extra;

    logic [15:0] r_crc, n_crc;
    logic [8:0]  r_total, n_total;
    logic [7:0]  r_tail0, n_tail0;
    logic [7:0]  r_tail1, n_tail1;
    logic [7:0]  r_func_byte, n_func_byte;
    logic [7:0]  r_third, n_third;
    logic [6:0]  r_attempt, n_attempt;
    logic        r_ovf, n_ovf;

    t_result     r_slot0, r_slot1;
    logic [1:0]  r_cnt;

    logic        w_accept;
    logic        w_push;
    logic        w_pop;
    t_result     w_res;
    logic [25:0] w_shifted;
    logic [15:0] w_backoff;

    assign o_stall  = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_slot0;
    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;

    assign w_shifted = 26'(r_base_delay) << r_attempt[3:0];
    always_comb begin
        if (r_attempt >= 7'd16 || w_shifted > {10'd0, r_delay_cap}) begin
            w_backoff = r_delay_cap;
        end else begin
            w_backoff = w_shifted[15:0];
        end
    end

    always_comb begin
        logic [15:0] b_crc;
        logic [8:0]  b_total;
        logic [7:0]  b_tail0, b_tail1, b_func, b_third;
        logic        b_ovf;
        logic        done;
        logic        retryable;

        b_crc   = r_crc;
        b_tail0 = r_tail0;
        b_tail1 = r_tail1;
        b_func  = r_func_byte;
        b_third = r_third;
        b_ovf   = r_ovf;
        b_total = r_total;
        if (r_total >= FRAME_LIMIT) begin
            b_ovf = 1'b1;
        end else begin
            if (r_total >= 9'd2) begin
                b_crc = crc16_step(r_crc, r_tail0);
            end
            b_tail0 = r_tail1;
            b_tail1 = i_item.rx_byte;
            if (r_total == 9'd1) begin
                b_func = i_item.rx_byte;
            end
            if (r_total == 9'd2) begin
                b_third = i_item.rx_byte;
            end
        end
        if (r_total < COUNT_SAT) begin
            b_total = r_total + 9'd1;
        end

        n_crc       = r_crc;
        n_total     = r_total;
        n_tail0     = r_tail0;
        n_tail1     = r_tail1;
        n_func_byte = r_func_byte;
        n_third     = r_third;
        n_ovf       = r_ovf;
        n_attempt   = r_attempt;
        done        = 1'b0;
        retryable   = 1'b0;
        w_res       = '0;
        w_res.status       = ST_OK;
        w_res.attempt      = r_attempt;
        w_res.frame_length = r_total;

        if (w_accept) begin
            unique case (i_item.func)
                FN_START: begin
                    n_attempt   = '0;
                    n_crc       = CRC_INIT;
                    n_total     = '0;
                    n_tail0     = '0;
                    n_tail1     = '0;
                    n_func_byte = '0;
                    n_third     = '0;
                    n_ovf       = 1'b0;
                end
                FN_BYTE: begin
                    n_crc       = b_crc;
                    n_total     = b_total;
                    n_tail0     = b_tail0;
                    n_tail1     = b_tail1;
                    n_func_byte = b_func;
                    n_third     = b_third;
                    n_ovf       = b_ovf;
                    w_res.frame_length = b_total;
                    if (i_item.end_of_frame) begin
                        done = 1'b1;
                        if (b_ovf) begin
                            w_res.status = ST_INVALID;
                        end else if (b_total < MIN_FRAME) begin
                            w_res.status = ST_SHORT;
                            retryable    = 1'b1;
                        end else if ({b_tail1, b_tail0} != b_crc) begin
                            w_res.status = ST_CRC;
                            retryable    = 1'b1;
                        end else if (b_func[7]) begin
                            w_res.status         = ST_EXCEPTION;
                            w_res.exception_code = b_third;
                            retryable = (b_third == EXC_ACK) || (b_third == EXC_BUSY)
                                || (b_third == r_busy_extra);
                        end
                    end
                end
                FN_TIMEOUT: begin
                    done         = 1'b1;
                    w_res.status = ST_TIMEOUT;
                    retryable    = 1'b1;
                end
                FN_LINK: begin
                    done         = 1'b1;
                    w_res.status = ST_INVALID;
                end
                default: begin
                    done = 1'b0;
                end
            endcase
        end

        w_res.retry = retryable && (r_attempt < r_retry_limit);
        if (w_res.retry) begin
            w_res.backoff_ms = w_backoff;
        end

        if (done) begin
            if (r_attempt < ATTEMPT_SAT) begin
                n_attempt = r_attempt + 7'd1;
            end
            n_crc       = CRC_INIT;
            n_total     = '0;
            n_tail0     = '0;
            n_tail1     = '0;
            n_func_byte = '0;
            n_third     = '0;
            n_ovf       = 1'b0;
        end
        w_push = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RST;
            r_base_delay  <= BASE_DELAY_RST;
            r_delay_cap   <= DELAY_CAP_RST;
            r_busy_extra  <= BUSY_EXTRA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[6:0];
                REG_BASE_DELAY:  r_base_delay  <= i_cfg_data[9:0];
                REG_DELAY_CAP:   r_delay_cap   <= i_cfg_data[15:0];
                REG_BUSY_EXTRA:  r_busy_extra  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_total     <= '0;
            r_tail0     <= '0;
            r_tail1     <= '0;
            r_func_byte <= '0;
            r_third     <= '0;
            r_ovf       <= 1'b0;
            r_attempt   <= '0;
        end else begin
            r_crc       <= n_crc;
            r_total     <= n_total;
            r_tail0     <= n_tail0;
            r_tail1     <= n_tail1;
            r_func_byte <= n_func_byte;
            r_third     <= n_third;
            r_ovf       <= n_ovf;
            r_attempt   <= n_attempt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !w_push) begin
            r_slot0 <= r_slot1;
        end else if (w_pop && w_push) begin
            if (r_cnt == 2'd1) begin
                r_slot0 <= w_res;
            end else begin
                r_slot0 <= r_slot1;
                r_slot1 <= w_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_slot0 <= w_res;
            end else begin
                r_slot1 <= w_res;
            end
        end
    end

endmodule

`default_nettype wire
